@@ hdl/shv_pkg.sv @@
// Shared types, constants and status codes for the sectioned header validator.
// Used by shv_core and sectioned_header_validator_top; depends on nothing else.
`timescale 1ns / 1ps

package shv_pkg;

  // Header geometry.
  localparam int unsigned HDR_LEN   = 40;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned SIZE_W    = 64;
  localparam int unsigned NUM_SECT  = 4;

  // Expected version value, little-endian over header bytes 4 to 7.
  localparam logic [7:0] VERSION_LO = 8'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TRUNCATED     = 3'd1,
    ST_BAD_MAGIC     = 3'd2,
    ST_BAD_VERSION   = 3'd3,
    ST_EMPTY_SECTION = 3'd4,
    ST_BAD_SIZES     = 3'd5
  } status_t;

  // One result item as it leaves the core.
  typedef struct packed {
    logic [SIZE_W-1:0] metadata_bytes;
    logic [SIZE_W-1:0] random_bytes;
    logic [SIZE_W-1:0] feature_bytes;
    logic [SIZE_W-1:0] request_bytes;
    status_t           status;
  } result_t;

  // Magic byte expected at header positions 0 to 3.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h42;  // 'B'
      2'd1:    b = 8'h32;  // '2'
      2'd2:    b = 8'h52;  // 'R'
      default: b = 8'h51;  // 'Q'
    endcase
    return b;
  endfunction

endpackage

@@ hdl/shv_core.sv @@
// Header parsing state and per-byte checks of the sectioned header validator.
// Depends on shv_pkg; instantiated by sectioned_header_validator_top.
`timescale 1ns / 1ps

module shv_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,          // one byte is processed this cycle
  input  logic                      frame_start,
  input  logic [7:0]                data_byte,
  input  logic [shv_pkg::SIZE_W-1:0] frame_length,
  output logic                      res_valid,
  output shv_pkg::result_t          res
);

  localparam logic [shv_pkg::POS_W-1:0] LAST_POS = shv_pkg::POS_W'(shv_pkg::HDR_LEN - 1);
  localparam logic [shv_pkg::POS_W-1:0] HDR_POS  = shv_pkg::POS_W'(shv_pkg::HDR_LEN);
  localparam logic [shv_pkg::SIZE_W-1:0] HDR_LEN64 = shv_pkg::SIZE_W'(shv_pkg::HDR_LEN);

  logic [shv_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       faulted_r, faulted_nxt;
  logic [shv_pkg::SIZE_W-1:0] acc_r, acc_nxt;
  logic [shv_pkg::SIZE_W-1:0] left_r, left_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       zero_r, zero_nxt;
  logic [shv_pkg::SIZE_W-1:0] sizes_r [shv_pkg::NUM_SECT-1];
  logic                       size_we;

  logic [shv_pkg::POS_W-1:0]  cur_pos;
  logic [1:0]                 sect_idx;
  logic [shv_pkg::SIZE_W:0]   sub;
  logic [7:0]                 ver_exp;
  logic                       any_zero;

  // Per-byte check and state update.
  always_comb begin
    pos_nxt     = pos_r;
    faulted_nxt = faulted_r;
    acc_nxt     = acc_r;
    left_nxt    = left_r;
    ovf_nxt     = ovf_r;
    zero_nxt    = zero_r;
    size_we     = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    res.status  = shv_pkg::ST_OK;

    cur_pos  = frame_start ? '0 : pos_r;
    sect_idx = 2'(cur_pos[5:3] - 3'd1);
    ver_exp  = (cur_pos[1:0] == 2'd0) ? shv_pkg::VERSION_LO : 8'd0;
    any_zero = 1'b0;

    if (step && frame_start) begin
      faulted_nxt = 1'b0;
      acc_nxt     = '0;
      ovf_nxt     = 1'b0;
      zero_nxt    = 1'b0;
      left_nxt    = frame_length - HDR_LEN64;
    end

    // Remaining budget less the size that completes at this byte.
    sub = {1'b0, left_r} - {1'b0, {data_byte, acc_r[shv_pkg::SIZE_W-1:8]}};

    if (step && frame_start && (frame_length < HDR_LEN64)) begin
      // Short frame: report at once and wait for the next start.
      left_nxt    = '0;
      faulted_nxt = 1'b1;
      res_valid   = 1'b1;
      res.status  = shv_pkg::ST_TRUNCATED;
    end else if (step && (frame_start || !faulted_r)) begin
      if (cur_pos >= HDR_POS) begin
        faulted_nxt = 1'b1;
      end else begin
        pos_nxt = cur_pos + 6'd1;
        if (cur_pos < 6'd4) begin
          // Magic bytes.
          if (data_byte != shv_pkg::magic_byte(cur_pos[1:0])) begin
            faulted_nxt = 1'b1;
            res_valid   = 1'b1;
            res.status  = shv_pkg::ST_BAD_MAGIC;
          end
        end else if (cur_pos < 6'd8) begin
          // Version bytes 2,0,0,0.
          if (data_byte != ver_exp) begin
            faulted_nxt = 1'b1;
            res_valid   = 1'b1;
            res.status  = shv_pkg::ST_BAD_VERSION;
          end
        end else begin
          // Section sizes, shifted in little-endian.
          acc_nxt = {data_byte, acc_r[shv_pkg::SIZE_W-1:8]};
          if (cur_pos[2:0] == 3'd7) begin
            any_zero = zero_r || (acc_nxt == '0);
            zero_nxt = any_zero;
            if (sect_idx != 2'd3) begin
              // Take this size from the remaining budget.
              size_we  = 1'b1;
              ovf_nxt  = ovf_r || sub[shv_pkg::SIZE_W];
              left_nxt = sub[shv_pkg::SIZE_W-1:0];
            end
          end
          if (cur_pos == LAST_POS) begin
            faulted_nxt = 1'b1;
            res_valid   = 1'b1;
            if (any_zero) begin
              res.status = shv_pkg::ST_EMPTY_SECTION;
            end else if (ovf_r || (acc_nxt != left_r)) begin
              res.status = shv_pkg::ST_BAD_SIZES;
            end else begin
              res.status         = shv_pkg::ST_OK;
              res.request_bytes  = sizes_r[0];
              res.feature_bytes  = sizes_r[1];
              res.random_bytes   = sizes_r[2];
              res.metadata_bytes = acc_nxt;
            end
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      faulted_r <= 1'b1;
      ovf_r     <= 1'b0;
      zero_r    <= 1'b0;
      acc_r     <= '0;
      left_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      faulted_r <= faulted_nxt;
      ovf_r     <= ovf_nxt;
      zero_r    <= zero_nxt;
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
    end
  end

  // Gathered sizes of the first three sections.
  always_ff @(posedge clk) begin
    if (size_we) begin
      sizes_r[sect_idx] <= acc_nxt;
    end
  end

endmodule

@@ hdl/sectioned_header_validator_top.sv @@
// Top level of the sectioned header validator: stream handshakes and registers.
// Depends on shv_pkg and shv_core.
`timescale 1ns / 1ps
//
//  Channel | Direction | Payload
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tuser: frame_start; tdata: data_byte, frame_length
//  out_    | master    | tdata: status, request/feature/random/metadata_bytes
//
//  One header byte is taken per cycle while the output is not stalled; each item
//  passes an input register and is checked from there, with any result held in an
//  output register. A result stays in the output register until it is taken.
//  A stalled output holds both stages; in_tready returns as soon as it drains.
//  Synchronous active-low reset leaves the block waiting for a frame start.

module sectioned_header_validator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // [7:0] data_byte, [71:8] frame_length
  input  logic         in_tuser,   // [0] frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata   // [2:0] status, [66:3] request_bytes,
                                   // [130:67] feature_bytes, [194:131] random_bytes,
                                   // [258:195] metadata_bytes, [263:259] zero
);

  logic                       s1_valid_r;
  logic                       s1_start_r;
  logic [7:0]                 s1_byte_r;
  logic [shv_pkg::SIZE_W-1:0] s1_len_r;
  logic                       out_valid_r;
  shv_pkg::result_t           out_res_r;
  logic                       s2_free;
  logic                       step;
  logic                       core_valid;
  shv_pkg::result_t           core_res;

  assign s2_free   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_free;
  assign step      = s1_valid_r && s2_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_start_r <= in_tuser;
      s1_byte_r  <= in_tdata[7:0];
      s1_len_r   <= in_tdata[71:8];
    end
  end

  shv_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .frame_start  (s1_start_r),
    .data_byte    (s1_byte_r),
    .frame_length (s1_len_r),
    .res_valid    (core_valid),
    .res          (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= step && core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

endmodule
